// ===== sv/dsim_pkg.sv =====
// ----------------------------------------------------------------------------
// dsim_pkg
// shared types and constants of the door security input monitor
// ----------------------------------------------------------------------------
package dsim_pkg;

  localparam int PinCount     = 4;
  localparam int CodeWidth    = 3;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;
  localparam int AgeWidth     = 8;
  localparam int DoorAgeWidth = 26;
  localparam int AccessWidth  = 16;
  localparam int MsPerSecond  = 1000;

  localparam logic [AgeWidth-1:0]     AgeMax     = '1;
  localparam logic [DoorAgeWidth-1:0] DoorAgeMax = '1;
  localparam logic [AccessWidth-1:0]  AccessMax  = '1;

  localparam logic [DoorAgeWidth-1:0] ResetHeldLimit = DoorAgeWidth'(30 * MsPerSecond);
  localparam logic [AgeWidth-1:0]     ResetDebounce  = AgeWidth'(60);
  localparam logic [AccessWidth-1:0]  ResetWindow    = AccessWidth'(3000);

  typedef enum logic [CodeWidth-1:0] {
    FN_DISABLED = 3'd0,
    FN_EXIT     = 3'd1,
    FN_DOOR     = 3'd2,
    FN_FIRE     = 3'd3,
    FN_TAMPER   = 3'd4
  } func_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_NC_MASK    = 3'd0,
    REG_FUNC_CODES = 3'd1,
    REG_FORCED_EN  = 3'd2,
    REG_HELD_SECS  = 3'd3,
    REG_DEBOUNCE   = 3'd4,
    REG_WINDOW     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic chg;
    logic lvl;
  } lane_out_t;

  typedef struct packed {
    logic                    door_is_open;
    logic [DoorAgeWidth-1:0] door_open_age;
    logic                    held_alert_done;
    logic                    access_pending;
    logic [AccessWidth-1:0]  access_age;
    logic                    fire_flag;
    logic                    tamper_flag;
  } mon_state_t;

  typedef struct packed {
    logic                    forced_en;
    logic [DoorAgeWidth-1:0] held_limit;
    logic [AccessWidth-1:0]  window;
  } merge_cfg_t;

  typedef struct packed {
    logic exit_request;
    logic forced_entry;
    logic door_opened;
    logic door_closed;
    logic fire_raised;
    logic fire_cleared;
    logic tamper_raised;
    logic tamper_cleared;
    logic door_held_alert;
    logic fire_active_now;
    logic tamper_active_now;
    logic door_open_now;
  } result_t;

endpackage

// ===== sv/dsim_in_if.sv =====
// ----------------------------------------------------------------------------
// dsim_in_if
// tick channel: raw pin levels and access grant pulse
// ----------------------------------------------------------------------------
interface dsim_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] pin_levels;
  logic       access_granted;

  modport source (output valid, output pin_levels, output access_granted, input ready);
  modport sink   (input valid, input pin_levels, input access_granted, output ready);
endinterface

// ===== sv/dsim_out_if.sv =====
// ----------------------------------------------------------------------------
// dsim_out_if
// result channel: event flags and status of one tick
// ----------------------------------------------------------------------------
interface dsim_out_if;
  logic valid;
  logic ready;
  logic exit_request;
  logic forced_entry;
  logic door_opened;
  logic door_closed;
  logic fire_raised;
  logic fire_cleared;
  logic tamper_raised;
  logic tamper_cleared;
  logic door_held_alert;
  logic fire_active_now;
  logic tamper_active_now;
  logic door_open_now;

  modport source (
    output valid, output exit_request, output forced_entry, output door_opened,
    output door_closed, output fire_raised, output fire_cleared, output tamper_raised,
    output tamper_cleared, output door_held_alert, output fire_active_now,
    output tamper_active_now, output door_open_now, input ready
  );
  modport sink (
    input valid, input exit_request, input forced_entry, input door_opened,
    input door_closed, input fire_raised, input fire_cleared, input tamper_raised,
    input tamper_cleared, input door_held_alert, input fire_active_now,
    input tamper_active_now, input door_open_now, output ready
  );
endinterface

// ===== sv/dsim_lane.sv =====
// ----------------------------------------------------------------------------
// dsim_lane
// one input pin: polarity mapping and stable-confirm debounce
// ----------------------------------------------------------------------------
module dsim_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                seeded,
  input  logic                                raw,
  input  logic                                nc,
  input  logic [dsim_pkg::AgeWidth-1:0]       debounce,
  output dsim_pkg::lane_out_t                 res
);

  logic                          accepted;
  logic                          accepted_next;
  logic                          candidate;
  logic                          candidate_next;
  logic [dsim_pkg::AgeWidth-1:0] age;
  logic [dsim_pkg::AgeWidth-1:0] age_next;
  logic                          trig;

  assign trig = nc ? raw : !raw;

  always_comb begin
    accepted_next  = accepted;
    candidate_next = candidate;
    age_next       = age;
    res            = '0;
    if (!seeded) begin
      accepted_next  = trig;
      candidate_next = trig;
      age_next       = '0;
    end else if (trig != candidate) begin
      candidate_next = trig;
      age_next       = '0;
    end else begin
      if (age != dsim_pkg::AgeMax) begin
        age_next = age + 1'b1;
      end
      if (trig != accepted && age_next >= debounce) begin
        accepted_next = trig;
        res.chg       = 1'b1;
      end
    end
    res.lvl = trig;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted  <= 1'b0;
      candidate <= 1'b0;
      age       <= '0;
    end else if (step) begin
      accepted  <= accepted_next;
      candidate <= candidate_next;
      age       <= age_next;
    end
  end

endmodule

// ===== sv/dsim_merge.sv =====
// ----------------------------------------------------------------------------
// dsim_merge
// combines lane changes in pin order into events and the next monitor state
// ----------------------------------------------------------------------------
module dsim_merge #(
  parameter int NUM_INPUTS = 4
) (
  input  dsim_pkg::lane_out_t  lanes [NUM_INPUTS],
  input  dsim_pkg::func_t      codes [NUM_INPUTS],
  input  dsim_pkg::merge_cfg_t cfg,
  input  dsim_pkg::mon_state_t st,
  input  logic                 grant,
  output dsim_pkg::mon_state_t st_next,
  output dsim_pkg::result_t    res
);

  always_comb begin
    st_next = st;
    res     = '0;

    // grant first, then the pending and door ages
    if (grant) begin
      st_next.access_pending = 1'b1;
      st_next.access_age     = '0;
    end else if (st.access_pending && st.access_age != dsim_pkg::AccessMax) begin
      st_next.access_age = st.access_age + 1'b1;
    end
    if (st.door_is_open && st.door_open_age != dsim_pkg::DoorAgeMax) begin
      st_next.door_open_age = st.door_open_age + 1'b1;
    end

    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (lanes[i].chg) begin
        case (codes[i])
          dsim_pkg::FN_EXIT: begin
            if (lanes[i].lvl) res.exit_request = 1'b1;
          end
          dsim_pkg::FN_DOOR: begin
            st_next.held_alert_done = 1'b0;
            if (lanes[i].lvl) begin
              st_next.door_is_open  = 1'b1;
              st_next.door_open_age = '0;
              if (cfg.forced_en &&
                  !(st_next.access_pending && st_next.access_age < cfg.window)) begin
                res.forced_entry = 1'b1;
              end
              st_next.access_pending = 1'b0;
              res.door_opened        = 1'b1;
            end else begin
              st_next.door_is_open = 1'b0;
              res.door_closed      = 1'b1;
            end
          end
          dsim_pkg::FN_FIRE: begin
            st_next.fire_flag = lanes[i].lvl;
            if (lanes[i].lvl) res.fire_raised = 1'b1;
            else res.fire_cleared = 1'b1;
          end
          dsim_pkg::FN_TAMPER: begin
            st_next.tamper_flag = lanes[i].lvl;
            if (lanes[i].lvl) res.tamper_raised = 1'b1;
            else res.tamper_cleared = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    if (st_next.door_is_open && !st_next.held_alert_done &&
        st_next.door_open_age > cfg.held_limit) begin
      st_next.held_alert_done = 1'b1;
      res.door_held_alert     = 1'b1;
    end

    res.fire_active_now   = st_next.fire_flag;
    res.tamper_active_now = st_next.tamper_flag;
    res.door_open_now     = st_next.door_is_open;
  end

endmodule

// ===== sv/door_security_input_monitor.sv =====
// ----------------------------------------------------------------------------
// door_security_input_monitor
// debounces door, exit, fire and tamper pins per millisecond tick and
// raises merged event flags with forced entry and held open checks
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    pin_levels, access_granted
//  out_ch   out  valid/ready    twelve event and status flags
//  cfg      in   cfg_we         cfg_index, cfg_data
//
//  one tick per cycle while no untaken result waits; its result is in the
//  output register in the cycle after; a new tick is taken while the result
//  waits, if the output is taken too; the lane debounce and merge logic are
//  combinational; synchronous reset clears state; the first tick after reset
//  only seeds; the held limit in ms is formed when held_open_seconds is written
// ----------------------------------------------------------------------------
module door_security_input_monitor #(
  parameter int NUM_INPUTS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dsim_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [dsim_pkg::CfgDataWidth-1:0]     cfg_data,
  dsim_in_if.sink                               in_ch,
  dsim_out_if.source                            out_ch
);

  logic [dsim_pkg::PinCount-1:0]                       nc_mask;
  logic [dsim_pkg::PinCount*dsim_pkg::CodeWidth-1:0]   func_codes;
  logic                                                forced_en;
  logic [dsim_pkg::DoorAgeWidth-1:0]                   held_limit;
  logic [dsim_pkg::AgeWidth-1:0]                       debounce;
  logic [dsim_pkg::AccessWidth-1:0]                    window;

  logic                 seeded;
  logic                 step;
  logic                 out_valid;
  dsim_pkg::result_t    out_word;
  dsim_pkg::mon_state_t st;
  dsim_pkg::mon_state_t st_next;
  dsim_pkg::result_t    res;
  dsim_pkg::merge_cfg_t mcfg;
  dsim_pkg::lane_out_t  lanes [NUM_INPUTS];
  dsim_pkg::func_t      codes [NUM_INPUTS];

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      nc_mask    <= '0;
      func_codes <= '0;
      forced_en  <= 1'b0;
      held_limit <= dsim_pkg::ResetHeldLimit;
      debounce   <= dsim_pkg::ResetDebounce;
      window     <= dsim_pkg::ResetWindow;
    end else if (cfg_we) begin
      unique case (dsim_pkg::cfg_reg_t'(cfg_index))
        dsim_pkg::REG_NC_MASK:    nc_mask    <= cfg_data[dsim_pkg::PinCount-1:0];
        dsim_pkg::REG_FUNC_CODES: func_codes <= cfg_data[dsim_pkg::PinCount*dsim_pkg::CodeWidth-1:0];
        dsim_pkg::REG_FORCED_EN:  forced_en  <= cfg_data[0];
        dsim_pkg::REG_HELD_SECS: begin
          held_limit <= dsim_pkg::DoorAgeWidth'(cfg_data) *
                        dsim_pkg::DoorAgeWidth'(dsim_pkg::MsPerSecond);
        end
        dsim_pkg::REG_DEBOUNCE:   debounce   <= cfg_data[dsim_pkg::AgeWidth-1:0];
        dsim_pkg::REG_WINDOW:     window     <= cfg_data[dsim_pkg::AccessWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
    logic raw;
    logic nc;
    if (i < dsim_pkg::PinCount) begin : g_pin
      assign raw      = in_ch.pin_levels[i];
      assign nc       = nc_mask[i];
      assign codes[i] = dsim_pkg::func_t'(func_codes[i*dsim_pkg::CodeWidth +: dsim_pkg::CodeWidth]);
    end else begin : g_spare
      assign raw      = 1'b0;
      assign nc       = 1'b0;
      assign codes[i] = dsim_pkg::FN_DISABLED;
    end
    dsim_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .seeded   (seeded),
      .raw      (raw),
      .nc       (nc),
      .debounce (debounce),
      .res      (lanes[i])
    );
  end

  assign mcfg.forced_en  = forced_en;
  assign mcfg.held_limit = held_limit;
  assign mcfg.window     = window;

  dsim_merge #(
    .NUM_INPUTS (NUM_INPUTS)
  ) u_merge (
    .lanes   (lanes),
    .codes   (codes),
    .cfg     (mcfg),
    .st      (st),
    .grant   (in_ch.access_granted),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded    <= 1'b0;
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        seeded <= 1'b1;
        st     <= st_next;
      end
      if (step) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_word <= res;
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.exit_request      = out_word.exit_request;
  assign out_ch.forced_entry      = out_word.forced_entry;
  assign out_ch.door_opened       = out_word.door_opened;
  assign out_ch.door_closed       = out_word.door_closed;
  assign out_ch.fire_raised       = out_word.fire_raised;
  assign out_ch.fire_cleared      = out_word.fire_cleared;
  assign out_ch.tamper_raised     = out_word.tamper_raised;
  assign out_ch.tamper_cleared    = out_word.tamper_cleared;
  assign out_ch.door_held_alert   = out_word.door_held_alert;
  assign out_ch.fire_active_now   = out_word.fire_active_now;
  assign out_ch.tamper_active_now = out_word.tamper_active_now;
  assign out_ch.door_open_now     = out_word.door_open_now;

  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted tick left no result");

  a_seed_quiet: assert property (@(posedge clk) disable iff (rst)
    step && !seeded |=> !(out_word.exit_request || out_word.door_opened ||
      out_word.door_closed || out_word.fire_raised || out_word.fire_cleared ||
      out_word.tamper_raised || out_word.tamper_cleared || out_word.forced_entry))
    else $error("event raised on seeding tick");

  a_forced_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.forced_entry |-> out_word.door_opened)
    else $error("forced entry without door opening");

  a_held_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.door_held_alert |-> out_word.door_open_now)
    else $error("held alert while door closed");

  a_held_once: assert property (@(posedge clk) disable iff (rst)
    step && st.held_alert_done && st.door_is_open && !res.door_opened &&
    !res.door_closed |-> !res.door_held_alert)
    else $error("held alert repeated in one opening");

endmodule

// ===== tb/door_event_checker.sv =====
// ----------------------------------------------------------------------------
// door_event_checker
// watches the tick and result channels of the door security input monitor,
// keeps its own copy of the debounce, door, fire and tamper state, predicts
// the flags of every accepted tick and compares them in order
// ----------------------------------------------------------------------------
module door_event_checker
  import dsim_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  dsim_in_if                      tick_w,
  dsim_out_if                     flag_w,
  output int                      fail_count,
  output int                      pending,
  output int                      checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // settings
  logic [PinCount-1:0]           nc_mask;
  logic [PinCount*CodeWidth-1:0] fn_codes;
  logic                          forced_en;
  logic [DoorAgeWidth-1:0]       held_limit;
  logic [AgeWidth-1:0]           debounce;
  logic [AccessWidth-1:0]        window;

  // tracked state
  logic                    seeded_done;
  logic [PinCount-1:0]     acc_lvl;
  logic [PinCount-1:0]     cand_lvl;
  logic [AgeWidth-1:0]     stab_age [PinCount];
  logic                    door_open;
  logic [DoorAgeWidth-1:0] door_age;
  logic                    held_done;
  logic                    grant_pending;
  logic [AccessWidth-1:0]  grant_age;
  logic                    fire_on;
  logic                    tamper_on;

  result_t flags_due [$];

  task automatic clear_all();
    nc_mask       = '0;
    fn_codes      = '0;
    forced_en     = 1'b0;
    held_limit    = ResetHeldLimit;
    debounce      = ResetDebounce;
    window        = ResetWindow;
    seeded_done   = 1'b0;
    acc_lvl       = '0;
    cand_lvl      = '0;
    for (int i = 0; i < PinCount; i++) stab_age[i] = '0;
    door_open     = 1'b0;
    door_age      = '0;
    held_done     = 1'b0;
    grant_pending = 1'b0;
    grant_age     = '0;
    fire_on       = 1'b0;
    tamper_on     = 1'b0;
    flags_due.delete();
  endtask

  task automatic write_setting(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    case (idx)
      REG_NC_MASK:    nc_mask = val[PinCount-1:0];
      REG_FUNC_CODES: fn_codes = val[PinCount*CodeWidth-1:0];
      REG_FORCED_EN:  forced_en = val[0];
      REG_HELD_SECS:  held_limit = DoorAgeWidth'(32'(val) * MsPerSecond);
      REG_DEBOUNCE:   debounce = val[AgeWidth-1:0];
      REG_WINDOW:     window = val[AccessWidth-1:0];
      default: ;
    endcase
  endtask

  function automatic result_t judge_tick(logic [PinCount-1:0] pins, logic grant);
    result_t r;
    logic    trig;
    r = '0;
    if (grant) begin
      grant_pending = 1'b1;
      grant_age     = '0;
    end else if (grant_pending && grant_age != AccessMax) begin
      grant_age++;
    end
    if (door_open && door_age != DoorAgeMax) door_age++;

    for (int i = 0; i < PinCount; i++) begin
      trig = nc_mask[i] ? pins[i] : ~pins[i];
      if (!seeded_done) begin
        acc_lvl[i]  = trig;
        cand_lvl[i] = trig;
        stab_age[i] = '0;
      end else if (trig != cand_lvl[i]) begin
        cand_lvl[i] = trig;
        stab_age[i] = '0;
      end else begin
        if (stab_age[i] != AgeMax) stab_age[i]++;
        if (trig != acc_lvl[i] && stab_age[i] >= debounce) begin
          acc_lvl[i] = trig;
          case (fn_codes[i*CodeWidth +: CodeWidth])
            FN_EXIT: if (trig) r.exit_request = 1'b1;
            FN_DOOR: begin
              held_done = 1'b0;
              if (trig) begin
                door_open = 1'b1;
                door_age  = '0;
                if (forced_en && !(grant_pending && grant_age < window))
                  r.forced_entry = 1'b1;
                grant_pending = 1'b0;
                r.door_opened = 1'b1;
              end else begin
                door_open     = 1'b0;
                r.door_closed = 1'b1;
              end
            end
            FN_FIRE: begin
              fire_on = trig;
              if (trig) r.fire_raised = 1'b1;
              else r.fire_cleared = 1'b1;
            end
            FN_TAMPER: begin
              tamper_on = trig;
              if (trig) r.tamper_raised = 1'b1;
              else r.tamper_cleared = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
    seeded_done = 1'b1;

    if (door_open && !held_done && door_age > held_limit) begin
      held_done         = 1'b1;
      r.door_held_alert = 1'b1;
    end
    r.fire_active_now   = fire_on;
    r.tamper_active_now = tamper_on;
    r.door_open_now     = door_open;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count < 30) $display("mismatch at result %0d: %s", checked, what);
    fail_count++;
  endtask

  task automatic check_flag(string label, logic got, logic want);
    if (got !== want) report_mismatch($sformatf("%s got %b want %b", label, got, want));
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      clear_all();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_we) write_setting(cfg_index, cfg_data);
      if (flag_w.valid && flag_w.ready) begin
        got = {flag_w.exit_request, flag_w.forced_entry, flag_w.door_opened,
               flag_w.door_closed, flag_w.fire_raised, flag_w.fire_cleared,
               flag_w.tamper_raised, flag_w.tamper_cleared, flag_w.door_held_alert,
               flag_w.fire_active_now, flag_w.tamper_active_now, flag_w.door_open_now};
        if (flags_due.size() == 0) begin
          report_mismatch("result word with no tick waiting");
        end else begin
          want = flags_due.pop_front();
          check_flag("exit_request", got.exit_request, want.exit_request);
          check_flag("forced_entry", got.forced_entry, want.forced_entry);
          check_flag("door_opened", got.door_opened, want.door_opened);
          check_flag("door_closed", got.door_closed, want.door_closed);
          check_flag("fire_raised", got.fire_raised, want.fire_raised);
          check_flag("fire_cleared", got.fire_cleared, want.fire_cleared);
          check_flag("tamper_raised", got.tamper_raised, want.tamper_raised);
          check_flag("tamper_cleared", got.tamper_cleared, want.tamper_cleared);
          check_flag("door_held_alert", got.door_held_alert, want.door_held_alert);
          check_flag("fire_active_now", got.fire_active_now, want.fire_active_now);
          check_flag("tamper_active_now", got.tamper_active_now, want.tamper_active_now);
          check_flag("door_open_now", got.door_open_now, want.door_open_now);
        end
        checked++;
      end
      if (tick_w.valid && tick_w.ready)
        flags_due.push_back(judge_tick(tick_w.pin_levels, tick_w.access_granted));
    end
    pending = flags_due.size();
  end

endmodule

// ===== tb/door_security_input_monitor_tb.sv =====
// ----------------------------------------------------------------------------
// door_security_input_monitor_tb
// drives millisecond ticks with held pin patterns, glitches and grant pulses
// through many register settings, with random gaps and stalls on both
// channels and one long output stall; the checker predicts and compares
// ----------------------------------------------------------------------------
module door_security_input_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsim_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;

  int            ticks_sent;
  int            phases;
  logic [7:0]    cur_debounce;
  logic [3:0]    pin_state;
  bit            gaps;
  bit            quiet;
  bit            hold_off_req;

  // {grant, pins}
  logic [4:0] mixed_ticks [16] = '{
    5'b0_0101, 5'b0_0101, 5'b0_1010, 5'b0_1010, 5'b0_1010, 5'b0_0101,
    5'b1_0101, 5'b0_0101, 5'b0_0111, 5'b0_0111, 5'b0_0101, 5'b0_0101,
    5'b1_0101, 5'b0_0101, 5'b0_0111, 5'b0_0111
  };
  logic [4:0] two_door_ticks [6] = '{
    5'b1_0000, 5'b0_0000, 5'b0_1111, 5'b0_1111, 5'b0_0000, 5'b0_0000
  };

  dsim_in_if  tick_ch ();
  dsim_out_if flag_ch ();

  door_security_input_monitor #(.NUM_INPUTS(PinCount)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (tick_ch),
    .out_ch    (flag_ch)
  );

  door_event_checker event_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_w     (tick_ch),
    .flag_w     (flag_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic apply_settings(logic [3:0] nc, logic [11:0] codes, logic forced,
                                logic [15:0] held, logic [7:0] deb, logic [15:0] win);
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_NC_MASK, CfgDataWidth'(nc));
    write_reg(REG_FUNC_CODES, CfgDataWidth'(codes));
    write_reg(REG_FORCED_EN, CfgDataWidth'(forced));
    write_reg(REG_HELD_SECS, held);
    write_reg(REG_DEBOUNCE, CfgDataWidth'(deb));
    write_reg(REG_WINDOW, win);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_debounce = deb;
    phases++;
  endtask

  task automatic send_tick(logic [3:0] pins, logic grant);
    @(negedge clk);
    if (gaps && !quiet && $urandom_range(0, 4) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    tick_ch.valid          <= 1'b1;
    tick_ch.pin_levels     <= pins;
    tick_ch.access_granted <= grant;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_list(logic [4:0] word);
    send_tick(word[3:0], word[4]);
  endtask

  // pin patterns held long enough to pass the debounce, with short glitches
  // and runs one tick too short mixed in; fixed bits stay at fixed_val
  task automatic drive_pattern(int n_ticks, logic [3:0] fixed_mask, logic [3:0] fixed_val);
    int         left;
    int         run;
    logic [3:0] flip;
    left = n_ticks;
    while (left > 0) begin
      flip      = 4'($urandom_range(1, 15));
      pin_state = ((pin_state ^ flip) & ~fixed_mask) | (fixed_val & fixed_mask);
      case ($urandom_range(0, 9))
        0:       run = $urandom_range(1, 2);
        1:       run = cur_debounce;
        default: run = cur_debounce + 1 + $urandom_range(0, 3);
      endcase
      if (run < 1) run = 1;
      if (run > left) run = left;
      repeat (run) begin
        send_tick(pin_state, $urandom_range(0, 11) == 0);
        left--;
      end
    end
  endtask

  task automatic random_phase(int n_ticks);
    logic [3:0]  nc;
    logic [11:0] codes;
    logic [15:0] held;
    logic [15:0] win;
    logic [7:0]  deb;
    int          r;
    nc = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 4) == 0) nc = $urandom_range(0, 1) ? 4'h0 : 4'hF;
    for (int i = 0; i < PinCount; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1:    codes[i*CodeWidth +: CodeWidth] = FN_DOOR;
        2, 3:    codes[i*CodeWidth +: CodeWidth] = FN_FIRE;
        4, 5:    codes[i*CodeWidth +: CodeWidth] = FN_TAMPER;
        6, 7:    codes[i*CodeWidth +: CodeWidth] = FN_EXIT;
        8:       codes[i*CodeWidth +: CodeWidth] = FN_DISABLED;
        default: codes[i*CodeWidth +: CodeWidth] = CodeWidth'($urandom_range(5, 7));
      endcase
    end
    r = $urandom_range(0, 9);
    held = (r < 6) ? 16'd0 : (r < 8) ? 16'hFFFF : 16'($urandom_range(1, 3));
    deb  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
    r = $urandom_range(0, 9);
    win  = (r < 7) ? 16'($urandom_range(0, 20)) : (r < 8) ? 16'd0 :
           (r < 9) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    apply_settings(nc, codes, 1'($urandom_range(0, 1)), held, deb, win);
    drive_pattern(n_ticks, 4'h0, 4'h0);
  endtask

  initial begin : ready_driver
    int stall_cycles;
    bit hold_off_served;
    hold_off_served = 1'b0;
    flag_ch.ready <= 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_off_req && !hold_off_served) begin
        hold_off_served = 1'b1;
        flag_ch.ready <= 1'b0;
        for (stall_cycles = 0; stall_cycles < 64; stall_cycles++) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        flag_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        flag_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = REG_NC_MASK;
    cfg_data               = '0;
    tick_ch.valid          = 1'b0;
    tick_ch.pin_levels     = '0;
    tick_ch.access_granted = 1'b0;
    ticks_sent             = 0;
    phases                 = 0;
    cur_debounce           = ResetDebounce;
    pin_state              = '0;
    gaps                   = 1'b1;
    quiet                  = 1'b0;
    hold_off_req           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // seeding tick, merged events, forced entry with and without grant,
    // held alert, grant window boundary
    apply_settings(4'b1010, {FN_TAMPER, FN_FIRE, FN_DOOR, FN_EXIT}, 1'b1, 16'd0, 8'd0,
                   16'd3);
    foreach (mixed_ticks[k]) send_list(mixed_ticks[k]);

    // two doors opening in one tick, unknown codes
    apply_settings(4'b0011, {3'd7, 3'd5, FN_DOOR, FN_DOOR}, 1'b1, 16'hFFFF, 8'd1,
                   16'hFFFF);
    foreach (two_door_ticks[k]) send_list(two_door_ticks[k]);

    for (int p = 0; p < 8; p++) begin
      gaps = $urandom_range(0, 2) != 0;
      if (p == 2) begin
        gaps         = 1'b0;
        hold_off_req = 1'b1;
      end
      random_phase(45);
    end

    gaps = 1'b1;
    apply_settings(4'hF, 12'hFFF, 1'b1, 16'hFFFF, 8'd0, 16'd0);
    drive_pattern(30, 4'h0, 4'h0);
    apply_settings(4'h0, 12'h000, 1'b0, 16'd0, 8'd0, 16'hFFFF);
    drive_pattern(30, 4'h0, 4'h0);

    apply_settings(4'($urandom_range(0, 15)), {FN_TAMPER, FN_FIRE, FN_DOOR, FN_EXIT},
                   1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);
    drive_pattern(340, 4'h0, 4'h0);

    // door on pin 0 held open past one second
    apply_settings(4'b0001, {FN_FIRE, FN_TAMPER, FN_EXIT, FN_DOOR}, 1'b1, 16'd1, 8'd0,
                   16'd5);
    drive_pattern(4, 4'b0001, 4'b0000);
    drive_pattern(1010, 4'b0001, 4'b0001);

    quiet = 1'b1;
    gaps  = 1'b0;
    random_phase(60);

    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("run: %0d ticks over %0d register settings, %0d result words compared",
             ticks_sent, phases, checked);
    $display("run: glitches, debounce 0 and 255, forced entry, held alert, output stall");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
